// ===== design/fqd_pkg.sv =====
// fqd_pkg: sizes, command codes and sequencer state codes for the FIFO queue
// with delete by value. No dependencies.
`timescale 1ns / 1ps

package fqd_pkg;

   // DEPTH is a power of two: slot indexes wrap by truncation.
   localparam int DEPTH      = 16;
   localparam int ITEM_WIDTH = 32;

   localparam int IDX_W = $clog2(DEPTH);
   localparam int CNT_W = $clog2(DEPTH + 1);
   localparam int CMD_W = 2;
   localparam int VAL_W = 32;
   localparam int OCC_W = 5;

   typedef logic [IDX_W-1:0]      idx_type;
   typedef logic [CNT_W-1:0]      cnt_type;
   typedef logic [ITEM_WIDTH-1:0] item_type;

   localparam logic [CMD_W-1:0] CMD_ENQ  = 2'd0;
   localparam logic [CMD_W-1:0] CMD_DEQ  = 2'd1;
   localparam logic [CMD_W-1:0] CMD_DEL  = 2'd2;
   localparam logic [CMD_W-1:0] CMD_ITER = 2'd3;

   localparam int ST_W = 2;
   localparam logic [ST_W-1:0] ST_IDLE = 2'd0;
   localparam logic [ST_W-1:0] ST_ITER = 2'd1;
   localparam logic [ST_W-1:0] ST_SRCH = 2'd2;
   localparam logic [ST_W-1:0] ST_MOVE = 2'd3;

endpackage

// ===== design/fqd_store.sv =====
// fqd_store: entry memory of the queue, one write port and one read port
// with registered read data. Depends on fqd_pkg.
`timescale 1ns / 1ps

module fqd_store
   import fqd_pkg::*;
(
   input  logic     clock,
   input  logic     wr_en,
   input  idx_type  wr_addr,
   input  item_type wr_data,
   input  logic     rd_en,
   input  idx_type  rd_addr,
   output item_type rd_data
);

   item_type mem_ff [DEPTH];
   item_type rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// ===== design/fifo_queue_with_delete_core.sv =====
// fifo_queue_with_delete_core: top level, command sequencer around one
// memory (one write port, one read port) and one value comparator. Depends on fqd_pkg and fqd_store.
//
//   channel   handshake            payload
//   request   start / busy         req_cmd, req_data_value
//   response  rsp_strobe           rsp_status, rsp_item_value, rsp_occupancy, rsp_last
//
// Enqueue, errors: result comes straight from the response registers. Dequeue: read
// data passes the store's read register, then the response registers. Iterate of N items: one beat per cycle.
// Delete on N items: search up to the match, then each entry behind it moves up
// one slot; when nothing matches, an error response once all N are searched.
// Reset clears head, count and sequencer; the memory is not cleared.
// Results cannot be stalled; busy holds off new commands until the last beat.
`timescale 1ns / 1ps

module fifo_queue_with_delete_core
   import fqd_pkg::*;
(
   input  logic             clock,
   input  logic             reset,
   input  logic             start,
   output logic             busy,
   input  logic [CMD_W-1:0] req_cmd,
   input  logic [VAL_W-1:0] req_data_value,
   output logic             rsp_strobe,
   output logic             rsp_status,
   output logic [VAL_W-1:0] rsp_item_value,
   output logic [OCC_W-1:0] rsp_occupancy,
   output logic             rsp_last
);

   logic [ST_W-1:0]  state_ff, state_in;
   idx_type          head_ff, head_in;
   cnt_type          count_ff, count_in;
   item_type         val_ff, val_in;
   cnt_type          idx_ff, idx_in;
   logic             emit_ff, emit_in;
   logic             elast_ff, elast_in;
   logic             chk_ff, chk_in;
   idx_type          chk_idx_ff, chk_idx_in;

   logic             strobe_ff, strobe_in;
   logic             status_ff, status_in;
   logic [VAL_W-1:0] item_ff, item_in;
   logic [OCC_W-1:0] occ_ff, occ_in;
   logic             last_ff, last_in;

   logic     accept;
   item_type req_val;
   logic     wr_en, rd_en;
   idx_type  wr_addr, rd_addr;
   item_type wr_data, rd_data;
   logic     match;
   cnt_type  idx_next;

   fqd_store u_store (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_data),
      .rd_en   (rd_en),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   assign busy     = (state_ff != ST_IDLE) || emit_ff;
   assign accept   = start && !busy;
   assign req_val  = req_data_value[ITEM_WIDTH-1:0];
   assign match    = chk_ff && (rd_data == val_ff);
   assign idx_next = CNT_W'(idx_ff + 1'b1);

   always_comb begin
      state_in   = state_ff;
      head_in    = head_ff;
      count_in   = count_ff;
      val_in     = val_ff;
      idx_in     = idx_ff;
      emit_in    = 1'b0;
      elast_in   = elast_ff;
      chk_in     = 1'b0;
      chk_idx_in = chk_idx_ff;
      strobe_in  = 1'b0;
      status_in  = status_ff;
      item_in    = item_ff;
      occ_in     = occ_ff;
      last_in    = last_ff;
      wr_en      = 1'b0;
      wr_addr    = IDX_W'(head_ff + count_ff[IDX_W-1:0]);
      wr_data    = req_val;
      rd_en      = 1'b0;
      rd_addr    = IDX_W'(head_ff + idx_ff[IDX_W-1:0]);

      // read data bound for the response channel
      if (emit_ff) begin
         strobe_in = 1'b1;
         status_in = 1'b0;
         item_in   = VAL_W'(rd_data);
         occ_in    = OCC_W'(count_ff);
         last_in   = elast_ff;
      end

      unique case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               val_in = req_val;
               idx_in = '0;
               case (req_cmd)
                  CMD_ENQ: begin
                     strobe_in = 1'b1;
                     item_in   = '0;
                     last_in   = 1'b1;
                     if (req_val == '0 || count_ff == CNT_W'(DEPTH)) begin
                        status_in = 1'b1;
                        occ_in    = OCC_W'(count_ff);
                     end else begin
                        wr_en     = 1'b1;
                        count_in  = CNT_W'(count_ff + 1'b1);
                        status_in = 1'b0;
                        occ_in    = OCC_W'(count_ff + 1'b1);
                     end
                  end
                  CMD_DEQ: begin
                     if (count_ff == '0) begin
                        strobe_in = 1'b1;
                        status_in = 1'b1;
                        item_in   = '0;
                        occ_in    = OCC_W'(count_ff);
                        last_in   = 1'b1;
                     end else begin
                        rd_en    = 1'b1;
                        rd_addr  = head_ff;
                        head_in  = IDX_W'(head_ff + 1'b1);
                        count_in = CNT_W'(count_ff - 1'b1);
                        emit_in  = 1'b1;
                        elast_in = 1'b1;
                     end
                  end
                  CMD_DEL, CMD_ITER: begin
                     if (count_ff == '0) begin
                        strobe_in = 1'b1;
                        status_in = 1'b1;
                        item_in   = '0;
                        occ_in    = OCC_W'(count_ff);
                        last_in   = 1'b1;
                     end else begin
                        state_in = (req_cmd == CMD_DEL) ? ST_SRCH : ST_ITER;
                     end
                  end
               endcase
            end
         end
         ST_ITER: begin
            rd_en    = 1'b1;
            emit_in  = 1'b1;
            elast_in = (idx_next == count_ff);
            idx_in   = idx_next;
            if (idx_next == count_ff) begin
               state_in = ST_IDLE;
            end
         end
         ST_SRCH: begin
            if (match) begin
               state_in = ST_MOVE;
               idx_in   = CNT_W'({1'b0, chk_idx_ff} + 1'b1);
            end else if (idx_ff < count_ff) begin
               rd_en      = 1'b1;
               chk_in     = 1'b1;
               chk_idx_in = idx_ff[IDX_W-1:0];
               idx_in     = idx_next;
            end else begin
               state_in  = ST_IDLE;
               strobe_in = 1'b1;
               status_in = 1'b1;
               item_in   = '0;
               occ_in    = OCC_W'(count_ff);
               last_in   = 1'b1;
            end
         end
         ST_MOVE: begin
            // entry k+1 read last cycle lands in slot k
            if (chk_ff) begin
               wr_en   = 1'b1;
               wr_addr = IDX_W'(head_ff + chk_idx_ff);
               wr_data = rd_data;
            end
            if (idx_ff < count_ff) begin
               rd_en      = 1'b1;
               chk_in     = 1'b1;
               chk_idx_in = IDX_W'(idx_ff[IDX_W-1:0] - 1'b1);
               idx_in     = idx_next;
            end else begin
               state_in  = ST_IDLE;
               count_in  = CNT_W'(count_ff - 1'b1);
               strobe_in = 1'b1;
               status_in = 1'b0;
               item_in   = '0;
               occ_in    = OCC_W'(count_ff - 1'b1);
               last_in   = 1'b1;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff  <= ST_IDLE;
         head_ff   <= '0;
         count_ff  <= '0;
         emit_ff   <= 1'b0;
         chk_ff    <= 1'b0;
         strobe_ff <= 1'b0;
      end else begin
         state_ff  <= state_in;
         head_ff   <= head_in;
         count_ff  <= count_in;
         emit_ff   <= emit_in;
         chk_ff    <= chk_in;
         strobe_ff <= strobe_in;
      end
   end

   always_ff @(posedge clock) begin
      val_ff     <= val_in;
      idx_ff     <= idx_in;
      elast_ff   <= elast_in;
      chk_idx_ff <= chk_idx_in;
      status_ff  <= status_in;
      item_ff    <= item_in;
      occ_ff     <= occ_in;
      last_ff    <= last_in;
   end

   assign rsp_strobe     = strobe_ff;
   assign rsp_status     = status_ff;
   assign rsp_item_value = item_ff;
   assign rsp_occupancy  = occ_ff;
   assign rsp_last       = last_ff;

`ifndef SYNTHESIS
   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CNT_W'(DEPTH))
      else $error("queue count above depth");

   a_beat_follows: assert property (@(posedge clock) disable iff (reset)
      (rsp_strobe && !rsp_last) |=> rsp_strobe)
      else $error("iterate beat stream broken");

   a_no_accept_mid_burst: assert property (@(posedge clock) disable iff (reset)
      (rsp_strobe && !rsp_last) |-> busy)
      else $error("command accepted during iterate burst");

   a_delete_dec: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_MOVE && state_in == ST_IDLE)
         |=> count_ff == CNT_W'($past(count_ff) - 1'b1))
      else $error("delete did not shrink the queue by one");
`endif

endmodule
